// ----- rtl/core/sspr_pkg.sv -----
`default_nettype none

package sspr_pkg;

    // command codes of an input beat
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [8:0]  LEN_INDEX     = 9'd3;   // index of the length byte
    localparam logic [8:0]  SUM_START     = 9'd2;   // first index in the checksum
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    typedef struct packed {
        logic        receiving;
        logic [8:0]  byte_count;
        logic [8:0]  end_index;
        logic [7:0]  running_sum;
        logic [15:0] idle_ticks;
    } t_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [8:0] byte_index;
        logic       last;
        logic       checksum_error;
        logic       timed_out;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/sspr_step.sv -----
`default_nettype none

// Next-state and result logic for one beat.
module sspr_step (
    input  wire sspr_pkg::t_cmd   i_cmd,
    input  wire logic [7:0]       i_rx_byte,
    input  wire logic [15:0]      i_limit,
    input  wire sspr_pkg::t_state i_state,
    output sspr_pkg::t_state      o_state,
    output sspr_pkg::t_result     o_result,
    output logic                  o_has_result
);

    logic [8:0]  idx;
    logic [8:0]  end_next;
    logic        is_last;
    logic [15:0] ticks_next;

    assign idx        = i_state.byte_count;
    assign end_next   = (idx == sspr_pkg::LEN_INDEX) ? ({1'b0, i_rx_byte} + 9'd3)
                                                     : i_state.end_index;
    assign is_last    = (idx >= sspr_pkg::LEN_INDEX) && (idx == end_next);
    assign ticks_next = (i_state.idle_ticks < sspr_pkg::TICK_MAX)
                        ? i_state.idle_ticks + 16'd1 : i_state.idle_ticks;

    always_comb begin
        o_state      = i_state;
        o_result     = '0;
        o_has_result = 1'b0;
        unique case (i_cmd)
            sspr_pkg::CMD_START: begin
                o_state.receiving   = 1'b1;
                o_state.byte_count  = '0;
                o_state.end_index   = sspr_pkg::LEN_INDEX;
                o_state.running_sum = '0;
                o_state.idle_ticks  = '0;
            end
            sspr_pkg::CMD_BYTE: begin
                if (i_state.receiving) begin
                    o_has_result        = 1'b1;
                    o_state.idle_ticks  = '0;
                    o_state.end_index   = end_next;
                    o_result.data_byte  = i_rx_byte;
                    o_result.byte_index = idx;
                    if (is_last) begin
                        o_state.receiving       = 1'b0;
                        o_result.last           = 1'b1;
                        o_result.checksum_error = (~i_state.running_sum != i_rx_byte);
                    end else begin
                        if (idx >= sspr_pkg::SUM_START) begin
                            o_state.running_sum = i_state.running_sum + i_rx_byte;
                        end
                        o_state.byte_count = idx + 9'd1;
                    end
                end
            end
            sspr_pkg::CMD_TICK: begin
                if (i_state.receiving) begin
                    o_state.idle_ticks = ticks_next;
                    if (ticks_next >= i_limit) begin
                        o_state.receiving   = 1'b0;
                        o_has_result        = 1'b1;
                        o_result.byte_index = idx;
                        o_result.last       = 1'b1;
                        o_result.timed_out  = 1'b1;
                    end
                end
            end
            default: begin
                // no-op code: nothing changes
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/servo_status_packet_receiver_core.sv -----
`default_nettype none

// Channel | direction | handshake               | payload
// in      | sink      | i_in_valid / o_in_ready | i_command, i_rx_byte
// out     | source    | o_out_valid/i_out_ready | o_data_byte, o_byte_index, o_last,
//         |           |                         | o_checksum_error, o_timed_out
// cfg     | sink      | i_cfg_valid/o_cfg_ready | i_cfg_data (timeout_limit)
//
// One beat per cycle sustained while the output is not stalled. An accepted
// beat is held in the input register, then the step logic updates the packet
// state and loads the output register, which drives the result channel.
// Synchronous active-low reset: idle, limit = 1000, no result pending.
// A stalled output holds the pipe; the input register keeps taking beats
// while it drains, so ready falls only when both registers are full.
module servo_status_packet_receiver_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input beats
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_rx_byte,
    // result beats
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_data_byte,
    output logic [8:0]      o_byte_index,
    output logic            o_last,
    output logic            o_checksum_error,
    output logic            o_timed_out,
    // configuration
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    // input register
    logic               r_s1_valid;
    sspr_pkg::t_cmd     r_s1_cmd;
    logic [7:0]         r_s1_byte;

    // packet state and config
    sspr_pkg::t_state   r_state;
    sspr_pkg::t_state   n_state;
    logic [15:0]        r_limit;

    // output register
    logic               r_out_valid;
    sspr_pkg::t_result  r_out;
    sspr_pkg::t_result  n_out;
    logic               n_has_result;

    logic               advance;

    // stage 1 moves on when the output slot is free or being drained
    assign advance     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || advance;
    assign o_cfg_ready = 1'b1;

    sspr_step u_step (
        .i_cmd        (r_s1_cmd),
        .i_rx_byte    (r_s1_byte),
        .i_limit      (r_limit),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_result     (n_out),
        .o_has_result (n_has_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_cmd  <= sspr_pkg::t_cmd'(i_command);
            r_s1_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= sspr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.receiving   <= 1'b0;
            r_state.byte_count  <= '0;
            r_state.end_index   <= sspr_pkg::LEN_INDEX;
            r_state.running_sum <= '0;
            r_state.idle_ticks  <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // output slot: load on a beat that yields a result, clear when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_has_result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_has_result) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_data_byte      = r_out.data_byte;
    assign o_byte_index     = r_out.byte_index;
    assign o_last           = r_out.last;
    assign o_checksum_error = r_out.checksum_error;
    assign o_timed_out      = r_out.timed_out;

endmodule

`default_nettype wire

// ----- verif/servo_status_packet_receiver_core_test.sv -----
`timescale 1ns / 100ps

module servo_status_packet_receiver_core_test;

    import sspr_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int PHASE_ITEMS  = 325;      // beats per random phase
    localparam int DRAIN_CYCLES = 8;        // pipe is two deep, leave margin
    localparam int LONG_HOLD    = 400;      // receiver hold-off, in cycles
    localparam logic [15:0] BURST_MAX_LIMIT = 16'd64;  // tick runs only up to this

    // Tracks packet state beat by beat and queues the result each beat produces.
    class status_scoreboard;
        logic [15:0] limit;
        bit          receiving;
        logic [8:0]  count;
        logic [8:0]  end_idx;
        logic [7:0]  sum;
        logic [15:0] ticks;
        t_result     expected_q[$];
        int          errors;

        function new();
            limit     = TIMEOUT_RESET;
            receiving = 1'b0;
            count     = '0;
            end_idx   = LEN_INDEX;
            sum       = '0;
            ticks     = '0;
            errors    = 0;
        endfunction

        function void set_limit(logic [15:0] value);
            limit = value;
        endfunction

        // Returns 1 when the beat had any effect on the packet state.
        function bit note_beat(t_cmd cmd, logic [7:0] b);
            t_result    r;
            logic [8:0] idx;
            r = '0;
            if (cmd == CMD_START) begin
                receiving = 1'b1;
                count     = '0;
                end_idx   = LEN_INDEX;
                sum       = '0;
                ticks     = '0;
                return 1'b1;
            end
            if (cmd == CMD_NOP || !receiving)
                return 1'b0;
            if (cmd == CMD_BYTE) begin
                idx   = count;
                ticks = '0;
                if (idx == LEN_INDEX)
                    end_idx = {1'b0, b} + LEN_INDEX;
                r.data_byte  = b;
                r.byte_index = idx;
                if (idx >= LEN_INDEX && idx == end_idx) begin
                    // final byte: compare against inverted running sum
                    r.last           = 1'b1;
                    r.checksum_error = ((~sum) != b);
                    receiving        = 1'b0;
                end else begin
                    if (idx >= SUM_START)
                        sum = sum + b;
                    count = idx + 9'd1;
                end
                expected_q.push_back(r);
            end else begin
                if (ticks != TICK_MAX)
                    ticks = ticks + 16'd1;
                if (ticks >= limit) begin
                    r.byte_index = count;
                    r.last       = 1'b1;
                    r.timed_out  = 1'b1;
                    receiving    = 1'b0;
                    expected_q.push_back(r);
                end
            end
            return 1'b1;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: data_byte %0d byte_index %0d",
                       got.data_byte, got.byte_index);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.data_byte != want.data_byte) begin
                $error("data_byte: expected %0d, actual %0d", want.data_byte, got.data_byte);
                errors++;
            end
            if (got.byte_index != want.byte_index) begin
                $error("byte_index: expected %0d, actual %0d",
                       want.byte_index, got.byte_index);
                errors++;
            end
            if (got.last != want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
            if (got.checksum_error != want.checksum_error) begin
                $error("checksum_error: expected %0d, actual %0d",
                       want.checksum_error, got.checksum_error);
                errors++;
            end
            if (got.timed_out != want.timed_out) begin
                $error("timed_out: expected %0d, actual %0d", want.timed_out, got.timed_out);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_cmd        command = CMD_NOP;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  data_byte;
    logic [8:0]  byte_index;
    logic        last;
    logic        checksum_error;
    logic        timed_out;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'd0;

    status_scoreboard sb;
    int  cycle_count = 0;
    int  phase_items = 0;
    bit  no_gaps = 1'b0;
    bit  burst = 1'b0;
    bit  hold_req = 1'b0;

    servo_status_packet_receiver_core u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_command        (command),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_data_byte      (data_byte),
        .o_byte_index     (byte_index),
        .o_last           (last),
        .o_checksum_error (checksum_error),
        .o_timed_out      (timed_out),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result monitor: sample handshake at the edge
    always @(posedge clk) begin
        t_result got;
        if (rst_n && out_valid && out_ready) begin
            got.data_byte      = data_byte;
            got.byte_index     = byte_index;
            got.last           = last;
            got.checksum_error = checksum_error;
            got.timed_out      = timed_out;
            sb.check_result(got);
        end
    end

    // receiver side: random stalls, plus one long hold-off on request
    initial begin
        int pick;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req <= 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end else if (pick < 92) begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end else begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                end
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        if (no_gaps || burst)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // One input beat; valid stays high straight into the next beat when no gap.
    task automatic send_beat(input t_cmd cmd, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        void'(sb.note_beat(cmd, b));
        phase_items++;
    endtask

    task automatic write_limit(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_limit(value);
    endtask

    // wait for every expected result, then let the pipe empty
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // run of ticks up to about the limit, only where the limit is short
    task automatic tick_burst();
        int n;
        if (sb.limit > BURST_MAX_LIMIT)
            return;
        n = (sb.limit == 16'd0) ? 1 : int'(sb.limit) - 1 + $urandom_range(0, 2);
        no_gaps = 1'b1;
        repeat (n) send_beat(CMD_TICK, 8'($urandom));
        no_gaps = 1'b0;
    endtask

    task automatic between_bytes();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            repeat ($urandom_range(1, 3)) send_beat(CMD_TICK, 8'($urandom));
        else if (pick < 24)
            tick_burst();
        else if (pick < 26)
            send_beat(CMD_NOP, 8'($urandom));
        else if (pick < 27)
            send_beat(CMD_START, 8'($urandom));
    endtask

    // Mostly well-formed status packets with random content; some cut short,
    // some with a bad checksum, some plain noise.
    task automatic send_packet();
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        int         n_bytes;
        int         cut;
        burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(1, 6))
                send_beat(t_cmd'($urandom_range(0, 3)), 8'($urandom));
        end else begin
            send_beat(CMD_START, 8'($urandom));
            len     = ($urandom_range(0, 39) == 0) ? 8'd255 : 8'($urandom_range(0, 6));
            n_bytes = int'(len) + 4;
            cut     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_bytes - 1) : n_bytes;
            sum     = '0;
            for (int k = 0; k < cut; k++) begin
                if (k < 2)
                    b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'hFF;
                else if (k == 3)
                    b = len;
                else if (k == n_bytes - 1)
                    b = ($urandom_range(0, 4) == 0) ? 8'($urandom) : ~sum;
                else
                    b = 8'($urandom);
                if (k >= 2 && k < n_bytes - 1)
                    sum = sum + b;
                send_beat(CMD_BYTE, b);
                between_bytes();
            end
        end
        burst = 1'b0;
    endtask

    task automatic run_random(input int target);
        phase_items = 0;
        while (phase_items < target) send_packet();
    endtask

    task automatic run_directed();
        // idle: byte, tick and unused code are all dropped
        send_beat(CMD_BYTE, 8'hA5);  send_beat(CMD_TICK, 8'h00);  send_beat(CMD_NOP, 8'hFF);
        // length zero: the length byte is itself last, sum covers the id only
        send_beat(CMD_START, 8'h00);
        send_beat(CMD_BYTE, 8'hFF);  send_beat(CMD_BYTE, 8'hFF);  send_beat(CMD_BYTE, 8'h01);
        send_beat(CMD_NOP, 8'h00);
        send_beat(CMD_BYTE, 8'h00);
        // length two, one parameter, good checksum, a tick in between
        send_beat(CMD_START, 8'hFF);
        send_beat(CMD_BYTE, 8'hFF);  send_beat(CMD_BYTE, 8'hFF);
        send_beat(CMD_BYTE, 8'h01);  send_beat(CMD_BYTE, 8'h02);
        send_beat(CMD_BYTE, 8'h00);  send_beat(CMD_TICK, 8'hFF);  send_beat(CMD_BYTE, 8'hFC);
        // restart mid-packet, then a maximum length header left open
        send_beat(CMD_START, 8'h00);
        send_beat(CMD_BYTE, 8'h00);  send_beat(CMD_BYTE, 8'hFF);
        send_beat(CMD_START, 8'h00);
        send_beat(CMD_BYTE, 8'h7E);  send_beat(CMD_BYTE, 8'h81);
        send_beat(CMD_BYTE, 8'hFF);  send_beat(CMD_BYTE, 8'hFF);
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit
        run_directed();
        run_random(PHASE_ITEMS);
        drain();

        // widest limit, with a long output stall while beats keep coming,
        // so the input side backs up
        write_limit(TICK_MAX);
        hold_req <= 1'b1;
        run_random(PHASE_ITEMS);
        drain();

        write_limit(16'd0);
        run_random(PHASE_ITEMS);
        drain();

        write_limit(16'd1);
        run_random(PHASE_ITEMS);
        drain();

        write_limit(16'($urandom_range(2, 50)));
        run_random(PHASE_ITEMS);
        drain();

        write_limit(TIMEOUT_RESET);
        run_random(PHASE_ITEMS);
        drain();

        if (sb.expected_q.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/sspr_pkg.sv
rtl/core/sspr_step.sv
rtl/core/servo_status_packet_receiver_core.sv
verif/servo_status_packet_receiver_core_test.sv
